// ----- rtl/cksb_pkg.sv -----
// ----------------------------------------------------------------------------
// cksb_pkg
// Types and constants shared by the color key sprite blitter.
// ----------------------------------------------------------------------------
package cksb_pkg;

    localparam int SCREEN_WIDTH   = 640;
    localparam int SCREEN_HEIGHT  = 480;
    localparam int MAX_SPRITE_DIM = 1024;

    localparam logic [7:0] KEY_LEVEL = 8'hFF;

    localparam int COLOR_W  = 8;
    localparam int POS_W    = 13;   // dest_x / dest_y
    localparam int DIM_W    = 11;   // sprite_width / sprite_height
    localparam int CNT_W    = $clog2(MAX_SPRITE_DIM);
    localparam int SX_W     = $clog2(SCREEN_WIDTH);
    localparam int SY_W     = $clog2(SCREEN_HEIGHT);
    localparam int ADDR_W   = 19;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int PADDR_W = 4;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_DEST_X        = 2'd0;
    localparam logic [1:0] REG_DEST_Y        = 2'd1;
    localparam logic [1:0] REG_SPRITE_WIDTH  = 2'd2;
    localparam logic [1:0] REG_SPRITE_HEIGHT = 2'd3;

    typedef struct packed {
        logic [POS_W-1:0] dest_x;
        logic [POS_W-1:0] dest_y;
        logic [DIM_W-1:0] sprite_width;
        logic [DIM_W-1:0] sprite_height;
    } t_blit_cfg;

    // classified pixel passed from front to back
    typedef struct packed {
        logic               we;
        logic [SX_W-1:0]    sx;
        logic [SY_W-1:0]    sy;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic               last;
    } t_blit_item;

    typedef struct packed {
        logic full;
        logic empty;
        logic [QCNT_W-1:0] level;
    } t_queue_status;

endpackage

// ----- rtl/cksb_front.sv -----
// ----------------------------------------------------------------------------
// cksb_front
// Sprite position counters; classifies each pixel (visible, key color, last).
// ----------------------------------------------------------------------------
module cksb_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cksb_pkg::t_blit_cfg         i_cfg,
    input  logic                        i_valid,
    input  logic [cksb_pkg::COLOR_W-1:0] i_red,
    input  logic [cksb_pkg::COLOR_W-1:0] i_green,
    input  logic [cksb_pkg::COLOR_W-1:0] i_blue,
    input  logic                        i_full,
    output logic                        o_ready,
    output logic                        o_push,
    output cksb_pkg::t_blit_item        o_item
);

    logic [cksb_pkg::CNT_W-1:0] r_col, n_col;
    logic [cksb_pkg::CNT_W-1:0] r_row, n_row;

    logic [cksb_pkg::DIM_W-1:0] w_clamp, h_clamp, w_m1, h_m1;
    logic [cksb_pkg::POS_W:0]   sx, sy;
    logic                       vis_x, vis_y, key, col_end, row_end, accept;

    function automatic logic [cksb_pkg::DIM_W-1:0] clamp_dim(
        input logic [cksb_pkg::DIM_W-1:0] v
    );
        logic [cksb_pkg::DIM_W-1:0] res;
        if (v == '0) begin
            res = cksb_pkg::DIM_W'(1);
        end else if (v > cksb_pkg::DIM_W'(cksb_pkg::MAX_SPRITE_DIM)) begin
            res = cksb_pkg::DIM_W'(cksb_pkg::MAX_SPRITE_DIM);
        end else begin
            res = v;
        end
        return res;
    endfunction

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept;

    always_comb begin
        w_clamp = clamp_dim(i_cfg.sprite_width);
        h_clamp = clamp_dim(i_cfg.sprite_height);
        w_m1    = w_clamp - cksb_pkg::DIM_W'(1);
        h_m1    = h_clamp - cksb_pkg::DIM_W'(1);
        col_end = cksb_pkg::DIM_W'(r_col) >= w_m1;
        row_end = cksb_pkg::DIM_W'(r_row) >= h_m1;

        // signed position, one bit wider than dest to hold the sum
        sx = {i_cfg.dest_x[cksb_pkg::POS_W-1], i_cfg.dest_x}
           + (cksb_pkg::POS_W+1)'(r_col);
        sy = {i_cfg.dest_y[cksb_pkg::POS_W-1], i_cfg.dest_y}
           + (cksb_pkg::POS_W+1)'(r_row);
        vis_x = !sx[cksb_pkg::POS_W]
             && (sx[cksb_pkg::POS_W-1:0] < cksb_pkg::POS_W'(cksb_pkg::SCREEN_WIDTH));
        vis_y = !sy[cksb_pkg::POS_W]
             && (sy[cksb_pkg::POS_W-1:0] < cksb_pkg::POS_W'(cksb_pkg::SCREEN_HEIGHT));
        key   = (i_red == cksb_pkg::KEY_LEVEL) && (i_green == '0)
             && (i_blue == cksb_pkg::KEY_LEVEL);

        o_item.we    = vis_x && vis_y && !key;
        o_item.sx    = sx[cksb_pkg::SX_W-1:0];
        o_item.sy    = sy[cksb_pkg::SY_W-1:0];
        o_item.red   = i_red;
        o_item.green = i_green;
        o_item.blue  = i_blue;
        o_item.last  = col_end && row_end;

        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (col_end) begin
                n_col = '0;
                n_row = row_end ? '0 : r_row + cksb_pkg::CNT_W'(1);
            end else begin
                n_col = r_col + cksb_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

// ----- rtl/cksb_queue.sv -----
// ----------------------------------------------------------------------------
// cksb_queue
// Short FIFO of classified pixels between the front and back parts.
// ----------------------------------------------------------------------------
module cksb_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  cksb_pkg::t_blit_item    i_item,
    input  logic                    i_pop,
    output cksb_pkg::t_blit_item    o_item,
    output cksb_pkg::t_queue_status o_status
);

    cksb_pkg::t_blit_item r_mem [cksb_pkg::QUEUE_DEPTH];

    logic [cksb_pkg::QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [cksb_pkg::QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [cksb_pkg::QCNT_W-1:0] r_count, n_count;
    logic                        do_push, do_pop;

    assign o_status.full  = (r_count == cksb_pkg::QCNT_W'(cksb_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_status.level = r_count;
    assign o_item         = r_mem[r_rd_ptr];

    always_comb begin
        do_push  = i_push && !o_status.full;
        do_pop   = i_pop && !o_status.empty;
        n_wr_ptr = do_push ? r_wr_ptr + cksb_pkg::QPTR_W'(1) : r_wr_ptr;
        n_rd_ptr = do_pop  ? r_rd_ptr + cksb_pkg::QPTR_W'(1) : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + cksb_pkg::QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - cksb_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ----- rtl/cksb_back.sv -----
// ----------------------------------------------------------------------------
// cksb_back
// Builds the framebuffer address and holds the result in an output register.
// ----------------------------------------------------------------------------
module cksb_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_empty,
    input  cksb_pkg::t_blit_item          i_item,
    output logic                          o_pop,
    input  logic                          i_ready,
    output logic                          o_valid,
    output logic                          o_we,
    output logic [cksb_pkg::ADDR_W-1:0]   o_addr,
    output logic [cksb_pkg::COLOR_W-1:0]  o_red,
    output logic [cksb_pkg::COLOR_W-1:0]  o_green,
    output logic [cksb_pkg::COLOR_W-1:0]  o_blue,
    output logic                          o_last
);

    logic                         r_valid;
    logic                         r_we;
    logic [cksb_pkg::ADDR_W-1:0]  r_addr, n_addr;
    logic [cksb_pkg::COLOR_W-1:0] r_red, r_green, r_blue;
    logic                         r_last;
    logic                         load;

    assign load  = !i_empty && (!r_valid || i_ready);
    assign o_pop = load;

    // constant multiply: shift-add in synthesis
    always_comb begin
        n_addr = cksb_pkg::ADDR_W'(i_item.sy) * cksb_pkg::ADDR_W'(cksb_pkg::SCREEN_WIDTH)
               + cksb_pkg::ADDR_W'(i_item.sx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_we    <= i_item.we;
            r_addr  <= i_item.we ? n_addr       : '0;
            r_red   <= i_item.we ? i_item.red   : '0;
            r_green <= i_item.we ? i_item.green : '0;
            r_blue  <= i_item.we ? i_item.blue  : '0;
            r_last  <= i_item.last;
        end
    end

    assign o_valid = r_valid;
    assign o_we    = r_we;
    assign o_addr  = r_addr;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;
    assign o_last  = r_last;

endmodule

// ----- rtl/color_key_sprite_blit_core.sv -----
// Each result passes through the queue write, then the output register.
// Throughput: 1 pixel per cycle sustained; the front stalls only when the 4-entry queue fills.
// Each pixel is classified in its accept cycle, the address add happens in the back part.
// Reset (synchronous, active low) clears the counters, queue and output valid and sets
// dest_x = dest_y = 0, sprite_width = sprite_height = 1.
// ----------------------------------------------------------------------------
// color_key_sprite_blit_core
// Color-keyed sprite blitter: one framebuffer write request per sprite pixel.
// ----------------------------------------------------------------------------
module color_key_sprite_blit_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // config port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cksb_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    // pixel input
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [23:0]                    i_s_tdata,  // pixel_red, pixel_green, pixel_blue
    // write requests
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // write_enable, write_address[18:0], out_red, out_green, out_blue, 4'b0 pad
    output logic [47:0]                    o_m_tdata,
    output logic                           o_m_tlast   // last_pixel
);

    cksb_pkg::t_blit_cfg     r_cfg;
    cksb_pkg::t_blit_item    front_item, queue_item;
    cksb_pkg::t_queue_status q_status;
    logic                    push, pop, cfg_wr;
    logic [1:0]              reg_idx;

    logic                          out_we;
    logic [cksb_pkg::ADDR_W-1:0]   out_addr;
    logic [cksb_pkg::COLOR_W-1:0]  out_red, out_green, out_blue;

    // ---------------- config registers ----------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dest_x        <= '0;
            r_cfg.dest_y        <= '0;
            r_cfg.sprite_width  <= cksb_pkg::DIM_W'(1);
            r_cfg.sprite_height <= cksb_pkg::DIM_W'(1);
        end else if (cfg_wr) begin
            case (reg_idx)
                cksb_pkg::REG_DEST_X:        r_cfg.dest_x        <= pwdata[cksb_pkg::POS_W-1:0];
                cksb_pkg::REG_DEST_Y:        r_cfg.dest_y        <= pwdata[cksb_pkg::POS_W-1:0];
                cksb_pkg::REG_SPRITE_WIDTH:  r_cfg.sprite_width  <= pwdata[cksb_pkg::DIM_W-1:0];
                cksb_pkg::REG_SPRITE_HEIGHT: r_cfg.sprite_height <= pwdata[cksb_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            cksb_pkg::REG_DEST_X:        prdata = 32'(r_cfg.dest_x);
            cksb_pkg::REG_DEST_Y:        prdata = 32'(r_cfg.dest_y);
            cksb_pkg::REG_SPRITE_WIDTH:  prdata = 32'(r_cfg.sprite_width);
            cksb_pkg::REG_SPRITE_HEIGHT: prdata = 32'(r_cfg.sprite_height);
            default:                     prdata = '0;
        endcase
    end

    // ---------------- datapath ----------------
    cksb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_s_tvalid),
        .i_red   (i_s_tdata[7:0]),
        .i_green (i_s_tdata[15:8]),
        .i_blue  (i_s_tdata[23:16]),
        .i_full  (q_status.full),
        .o_ready (o_s_tready),
        .o_push  (push),
        .o_item  (front_item)
    );

    cksb_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (front_item),
        .i_pop    (pop),
        .o_item   (queue_item),
        .o_status (q_status)
    );

    cksb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_status.empty),
        .i_item  (queue_item),
        .o_pop   (pop),
        .i_ready (i_m_tready),
        .o_valid (o_m_tvalid),
        .o_we    (out_we),
        .o_addr  (out_addr),
        .o_red   (out_red),
        .o_green (out_green),
        .o_blue  (out_blue),
        .o_last  (o_m_tlast)
    );

    assign o_m_tdata = {4'b0, out_blue, out_green, out_red, out_addr, out_we};

    // ---------------- assertions ----------------
    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !out_we) |-> (out_addr == '0 && out_red == '0
                                     && out_green == '0 && out_blue == '0))
        else $error("suppressed write carries nonzero payload");

    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && out_we) |->
            (out_addr < cksb_pkg::ADDR_W'(cksb_pkg::SCREEN_WIDTH * cksb_pkg::SCREEN_HEIGHT)))
        else $error("write address beyond framebuffer");

    a_queue_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.level <= cksb_pkg::QCNT_W'(cksb_pkg::QUEUE_DEPTH))
        else $error("queue level overflow");

    a_ready_when_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !q_status.full |-> o_s_tready)
        else $error("input stalled with room in queue");

endmodule
